@@ sv/ptw_pkg.sv @@
`default_nettype none

package ptw_pkg;

	localparam int ADDR_W  = 48;
	localparam int BASE_W  = 64;
	localparam int ENTRY_W = 32;
	localparam int IDX_W   = 10;

	// configuration register indexes
	localparam logic REG_WINDOW_BASE = 1'b0;
	localparam logic REG_SECOND_BASE = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_FAULT = 2'd2;
	localparam logic [1:0] KIND_MODE  = 2'd3;

	// actions
	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_DATA    = 1'b1;

	// format select in table_base[3:0]
	localparam logic [3:0] MODE_TWO   = 4'd1;
	localparam logic [3:0] MODE_THREE = 4'd2;
	localparam logic [3:0] MODE_FOUR  = 4'd3;
	localparam logic [3:0] MODE_SPLIT = 4'd5;

	// stored walk format
	localparam logic [1:0] FMT_TWO   = 2'd0;
	localparam logic [1:0] FMT_THREE = 2'd1;
	localparam logic [1:0] FMT_FOUR  = 2'd2;

	localparam int          SPLIT_BIT = 31;
	localparam logic [47:0] TAG_TWO   = 48'h0000_FFFF_F000;
	localparam logic [47:0] TAG_THREE = 48'h007F_FFFF_F000;
	localparam logic [47:0] TAG_FOUR  = 48'hFFFF_FFFF_F000;

	typedef struct packed {
		logic              busy;
		logic [1:0]        fmt;
		logic [1:0]        levels;
		logic [ADDR_W-1:0] addr;
	} walk_state_t;

	typedef struct packed {
		logic               action;
		logic [BASE_W-1:0]  table_base;
		logic [ADDR_W-1:0]  fault_address;
		logic [ENTRY_W-1:0] read_data;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ADDR_W-1:0]  read_address;
		logic [ENTRY_W-1:0] tlb_low;
		logic [ADDR_W-1:0]  tlb_high;
	} result_t;

	function automatic logic [IDX_W-1:0] table_index(input logic [1:0] fmt,
			input logic [1:0] lvl, input logic [ADDR_W-1:0] va);
		logic [IDX_W-1:0] idx;
		idx = '0;
		if (fmt == FMT_TWO) begin
			case (lvl)
				2'd0: idx = va[21:12];
				2'd1: idx = va[31:22];
				2'd2: idx = va[41:32];
				default: idx = {4'b0, va[47:42]};
			endcase
		end else begin
			case (lvl)
				2'd0: idx = {1'b0, va[20:12]};
				2'd1: idx = {1'b0, va[29:21]};
				2'd2: idx = {1'b0, va[38:30]};
				default: idx = {1'b0, va[47:39]};
			endcase
		end
		return idx;
	endfunction

	function automatic logic [ADDR_W-1:0] table_addr(input logic [ADDR_W-1:0] window,
			input logic [BASE_W-1:0] base, input logic [IDX_W-1:0] idx);
		return window + {19'b0, base[28:12], 12'b0} + {36'b0, idx, 2'b0};
	endfunction

	function automatic logic [ADDR_W-1:0] tag_mask(input logic [1:0] fmt);
		logic [ADDR_W-1:0] m;
		case (fmt)
			FMT_TWO:   m = TAG_TWO;
			FMT_THREE: m = TAG_THREE;
			default:   m = TAG_FOUR;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ sv/ptw_step.sv @@
`default_nettype none

module ptw_step (
	input  ptw_pkg::walk_state_t        cur,
	input  ptw_pkg::item_t              item,
	input  logic [ptw_pkg::ADDR_W-1:0]  window,
	input  logic [ptw_pkg::BASE_W-1:0]  second_base,
	output ptw_pkg::walk_state_t        nxt,
	output logic                        has_result,
	output ptw_pkg::result_t            res
);

	logic [ptw_pkg::BASE_W-1:0] base;
	logic [ptw_pkg::IDX_W-1:0]  idx;
	logic                       supported;

	always_comb begin
		nxt        = cur;
		has_result = 1'b0;
		res        = '0;
		base       = item.table_base;
		supported  = 1'b1;

		if (item.action == ptw_pkg::ACT_REQUEST) begin
			// a new request abandons any walk in progress
			nxt.busy = 1'b0;
			unique case (item.table_base[3:0])
				ptw_pkg::MODE_TWO: begin
					nxt.fmt    = ptw_pkg::FMT_TWO;
					nxt.levels = 2'd1;
				end
				ptw_pkg::MODE_THREE: begin
					nxt.fmt    = ptw_pkg::FMT_THREE;
					nxt.levels = 2'd2;
				end
				ptw_pkg::MODE_FOUR: begin
					nxt.fmt    = ptw_pkg::FMT_FOUR;
					nxt.levels = 2'd3;
				end
				ptw_pkg::MODE_SPLIT: begin
					nxt.fmt    = ptw_pkg::FMT_TWO;
					nxt.levels = 2'd1;
					if (item.fault_address[ptw_pkg::SPLIT_BIT])
						base = second_base;
				end
				default: begin
					nxt.fmt    = ptw_pkg::FMT_TWO;
					nxt.levels = 2'd0;
					supported  = 1'b0;
				end
			endcase
			has_result = 1'b1;
			if (supported) begin
				nxt.addr = item.fault_address;
				nxt.busy = 1'b1;
				res.kind = ptw_pkg::KIND_READ;
			end else begin
				res.kind = ptw_pkg::KIND_MODE;
			end
		end else if (cur.busy) begin
			has_result = 1'b1;
			base       = {32'b0, item.read_data};
			if (!item.read_data[0]) begin
				nxt.busy = 1'b0;
				res.kind = ptw_pkg::KIND_FAULT;
			end else if (cur.levels == 2'd0) begin
				nxt.busy     = 1'b0;
				res.kind     = ptw_pkg::KIND_LOAD;
				res.tlb_low  = item.read_data;
				res.tlb_high = cur.addr & ptw_pkg::tag_mask(cur.fmt);
			end else begin
				nxt.levels = cur.levels - 2'd1;
				res.kind   = ptw_pkg::KIND_READ;
			end
		end

		// index comes from the updated walk position
		idx = ptw_pkg::table_index(nxt.fmt, nxt.levels, nxt.addr);
		if (has_result && res.kind == ptw_pkg::KIND_READ)
			res.read_address = ptw_pkg::table_addr(window, base, idx);
	end

endmodule

`default_nettype wire

@@ sv/page_table_walker.sv @@
// throughput: one transaction per cycle unless the output stalls; each accepted
// item waits in the input register, which feeds one compute stage and an output
// register; the walk state is updated as each item leaves stage one
// a response that arrives while idle is consumed without a result
// reset (arst_n low, asynchronous) clears walk state, config registers and valids
`default_nettype none

module page_table_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [ptw_pkg::BASE_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [ptw_pkg::BASE_W-1:0]   table_base,
	input  logic [ptw_pkg::ADDR_W-1:0]   fault_address,
	input  logic [ptw_pkg::ENTRY_W-1:0]  read_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   result_kind,
	output logic [ptw_pkg::ADDR_W-1:0]   read_address,
	output logic [ptw_pkg::ENTRY_W-1:0]  tlb_low,
	output logic [ptw_pkg::ADDR_W-1:0]   tlb_high
);

	logic [ptw_pkg::ADDR_W-1:0] window_q;
	logic [ptw_pkg::BASE_W-1:0] second_base_q;

	ptw_pkg::walk_state_t walk_q;
	ptw_pkg::walk_state_t walk_nxt;

	logic            valid_s1;
	ptw_pkg::item_t  item_s1;

	logic             has_result;
	ptw_pkg::result_t res;

	logic             out_valid_q;
	ptw_pkg::result_t out_q;

	logic out_free;
	logic advance;
	logic emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= '0;
			second_base_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == ptw_pkg::REG_WINDOW_BASE)
				window_q <= cfg_data[ptw_pkg::ADDR_W-1:0];
			else
				second_base_q <= cfg_data;
		end
	end

	ptw_step u_step (
		.cur         (walk_q),
		.item        (item_s1),
		.window      (window_q),
		.second_base (second_base_q),
		.nxt         (walk_nxt),
		.has_result  (has_result),
		.res         (res)
	);

	assign out_free = !out_valid_q || out_ready;
	// items without a result drain even while the output is stalled
	assign advance  = valid_s1 && (out_free || !has_result);
	assign emit     = advance && has_result;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action        <= action;
			item_s1.table_base    <= table_base;
			item_s1.fault_address <= fault_address;
			item_s1.read_data     <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			walk_q <= '0;
		else if (advance)
			walk_q <= walk_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign read_address = out_q.read_address;
	assign tlb_low      = out_q.tlb_low;
	assign tlb_high     = out_q.tlb_high;

endmodule

`default_nettype wire

@@ sv/ptw_checker.sv @@
`default_nettype none

module ptw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   result_kind,
	input logic [ptw_pkg::ADDR_W-1:0]   read_address,
	input logic [ptw_pkg::ENTRY_W-1:0]  tlb_low,
	input logic [ptw_pkg::ADDR_W-1:0]   tlb_high
);

	// stalled result transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(read_address) && $stable(tlb_low) && $stable(tlb_high))
		else $error("result changed while stalled");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == ptw_pkg::KIND_READ |-> tlb_low == '0 && tlb_high == '0)
		else $error("read request carries tlb data");

	a_load_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == ptw_pkg::KIND_LOAD
			|-> read_address == '0 && tlb_high[11:0] == '0 && tlb_low[0])
		else $error("tlb load malformed");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == ptw_pkg::KIND_FAULT || result_kind == ptw_pkg::KIND_MODE)
			|-> read_address == '0 && tlb_low == '0 && tlb_high == '0)
		else $error("fault or mode error carries data");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_kind  (result_kind),
	.read_address (read_address),
	.tlb_low      (tlb_low),
	.tlb_high     (tlb_high)
);

`default_nettype wire

@@ verif/page_table_walker_checker.sv @@
`timescale 1ns / 1ps

module page_table_walker_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [ptw_pkg::BASE_W-1:0]   cfg_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         action,
	input  logic [ptw_pkg::BASE_W-1:0]   table_base,
	input  logic [ptw_pkg::ADDR_W-1:0]   fault_address,
	input  logic [ptw_pkg::ENTRY_W-1:0]  read_data,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [1:0]                   result_kind,
	input  logic [ptw_pkg::ADDR_W-1:0]   read_address,
	input  logic [ptw_pkg::ENTRY_W-1:0]  tlb_low,
	input  logic [ptw_pkg::ADDR_W-1:0]   tlb_high,
	output int                           fail_count,
	output int                           pending
);

	import ptw_pkg::*;

	logic [ADDR_W-1:0] window_base = '0;
	logic [BASE_W-1:0] split_base = '0;

	// walk in progress as the block should see it
	logic              walking = 1'b0;
	logic [1:0]        walk_fmt = FMT_TWO;
	logic [1:0]        levels_to_go = 2'd0;
	logic [ADDR_W-1:0] miss_va = '0;

	result_t expected_q[$];
	int      fails = 0;
	item_t   seen_item;

	assign fail_count = fails;
	assign seen_item = {action, table_base, fault_address, read_data};

	// address of the entry for the level being read
	function automatic logic [ADDR_W-1:0] entry_address(input logic [BASE_W-1:0] base);
		int unsigned       shift;
		logic [ADDR_W-1:0] idx;
		if (walk_fmt == FMT_TWO) begin
			shift = 12 + 10 * levels_to_go;
			idx = (miss_va >> shift) & 48'h3FF;
		end else begin
			shift = 12 + 9 * levels_to_go;
			idx = (miss_va >> shift) & 48'h1FF;
		end
		return window_base + (base[ADDR_W-1:0] & 48'h1FFF_F000) + (idx << 2);
	endfunction

	task automatic predict_walk(input item_t it);
		result_t           res;
		logic [BASE_W-1:0] base;
		res = '0;
		if (it.action == ACT_REQUEST) begin
			base = it.table_base;
			walking = 1'b0;
			case (base[3:0])
				MODE_TWO: begin
					walk_fmt = FMT_TWO;
					levels_to_go = 2'd1;
				end
				MODE_THREE: begin
					walk_fmt = FMT_THREE;
					levels_to_go = 2'd2;
				end
				MODE_FOUR: begin
					walk_fmt = FMT_FOUR;
					levels_to_go = 2'd3;
				end
				MODE_SPLIT: begin
					walk_fmt = FMT_TWO;
					levels_to_go = 2'd1;
					if (it.fault_address[SPLIT_BIT])
						base = split_base;
				end
				default: begin
					walk_fmt = FMT_TWO;
					levels_to_go = 2'd0;
					res.kind = KIND_MODE;
					expected_q.push_back(res);
					return;
				end
			endcase
			miss_va = it.fault_address;
			walking = 1'b1;
			res.kind = KIND_READ;
			res.read_address = entry_address(base);
			expected_q.push_back(res);
		end else if (walking) begin
			if (!it.read_data[0]) begin
				walking = 1'b0;
				res.kind = KIND_FAULT;
			end else if (levels_to_go == 2'd0) begin
				walking = 1'b0;
				res.kind = KIND_LOAD;
				res.tlb_low = it.read_data;
				case (walk_fmt)
					FMT_TWO:   res.tlb_high = miss_va & TAG_TWO;
					FMT_THREE: res.tlb_high = miss_va & TAG_THREE;
					default:   res.tlb_high = miss_va & TAG_FOUR;
				endcase
			end else begin
				levels_to_go = levels_to_go - 2'd1;
				res.kind = KIND_READ;
				res.read_address = entry_address({32'b0, it.read_data});
			end
			expected_q.push_back(res);
		end
	endtask

	function automatic void compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endfunction

	task automatic check_result();
		result_t want;
		if (expected_q.size() == 0) begin
			fails++;
			$display("%0t: expected none, actual kind %0d addr %h low %h high %h",
				$time, result_kind, read_address, tlb_low, tlb_high);
			return;
		end
		want = expected_q.pop_front();
		compare_field("result_kind", 64'(want.kind), 64'(result_kind));
		compare_field("read_address", 64'(want.read_address), 64'(read_address));
		compare_field("tlb_low", 64'(want.tlb_low), 64'(tlb_low));
		compare_field("tlb_high", 64'(want.tlb_high), 64'(tlb_high));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base = '0;
			split_base = '0;
			walking = 1'b0;
			walk_fmt = FMT_TWO;
			levels_to_go = 2'd0;
			miss_va = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_WINDOW_BASE)
					window_base = cfg_data[ADDR_W-1:0];
				else
					split_base = cfg_data;
			end
			if (in_valid && in_ready)
				predict_walk(seen_item);
			if (out_valid && out_ready)
				check_result();
			pending <= expected_q.size();
		end
	end

endmodule

@@ verif/page_table_walker_tb.sv @@
`timescale 1ns / 1ps

module page_table_walker_tb;

	import ptw_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 160;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_index;
	logic [BASE_W-1:0]  cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [BASE_W-1:0]  table_base;
	logic [ADDR_W-1:0]  fault_address;
	logic [ENTRY_W-1:0] read_data;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         result_kind;
	logic [ADDR_W-1:0]  read_address;
	logic [ENTRY_W-1:0] tlb_low;
	logic [ADDR_W-1:0]  tlb_high;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	page_table_walker dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .table_base(table_base),
		.fault_address(fault_address), .read_data(read_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .read_address(read_address),
		.tlb_low(tlb_low), .tlb_high(tlb_high)
	);

	page_table_walker_checker walk_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .table_base(table_base),
		.fault_address(fault_address), .read_data(read_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .read_address(read_address),
		.tlb_low(tlb_low), .tlb_high(tlb_high),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// no transaction on either side for too long means the block is stuck
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic item_t junk_item();
		item_t it;
		it.action = 1'($urandom_range(1));
		it.table_base = {$urandom, $urandom};
		it.fault_address = 48'({$urandom, $urandom});
		it.read_data = $urandom;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		table_base <= it.table_base;
		fault_address <= it.fault_address;
		read_data <= it.read_data;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
	endtask

	// unused fields carry random values
	task automatic send_request(input logic [BASE_W-1:0] base, input logic [ADDR_W-1:0] va);
		item_t it;
		it = junk_item();
		it.action = ACT_REQUEST;
		it.table_base = base;
		it.fault_address = va;
		send_item(it);
	endtask

	task automatic send_entry(input logic [ENTRY_W-1:0] entry);
		item_t it;
		it = junk_item();
		it.action = ACT_DATA;
		it.read_data = entry;
		send_item(it);
	endtask

	// hold off until every result is out and the pipeline has emptied
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [ADDR_W-1:0] window, input logic [BASE_W-1:0] second);
		cfg_write <= 1'b1;
		cfg_index <= REG_WINDOW_BASE;
		cfg_data <= {16'($urandom), window};
		@(posedge clk);
		cfg_index <= REG_SECOND_BASE;
		cfg_data <= second;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// one walk: mostly complete ones, some faults, some cut short by the next request
	task automatic random_walk(output int counted);
		int                 pick;
		int                 depth;
		logic [3:0]         mode;
		logic [BASE_W-1:0]  base;
		logic [ENTRY_W-1:0] entry;
		counted = 0;
		pick = $urandom_range(99);
		if (pick >= 94) begin
			send_entry($urandom);
			counted = 1;
			return;
		end
		if (pick < 20)
			mode = MODE_TWO;
		else if (pick < 40)
			mode = MODE_THREE;
		else if (pick < 64)
			mode = MODE_FOUR;
		else if (pick < 86)
			mode = MODE_SPLIT;
		else begin
			do
				mode = 4'($urandom_range(15));
			while (mode == MODE_TWO || mode == MODE_THREE || mode == MODE_FOUR ||
				mode == MODE_SPLIT);
		end
		base = {$urandom, $urandom};
		base[3:0] = mode;
		send_request(base, 48'({$urandom, $urandom}));
		counted = 1;
		case (mode)
			MODE_TWO, MODE_SPLIT: depth = 2;
			MODE_THREE:           depth = 3;
			MODE_FOUR:            depth = 4;
			default:              depth = 0;
		endcase
		for (int lvl = 0; lvl < depth; lvl++) begin
			if ($urandom_range(99) < 4)
				return;
			entry = $urandom;
			entry[0] = ($urandom_range(99) >= 8);
			send_entry(entry);
			counted++;
			if (!entry[0])
				return;
		end
	endtask

	initial begin
		int sent;
		int n;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_WINDOW_BASE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= ACT_REQUEST;
		table_base <= '0;
		fault_address <= '0;
		read_data <= '0;
		out_ready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: window wraps past the top, split base with mode bits set
		write_regs(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request({60'hFFF_FFFF_FFFF_FFFF, MODE_TWO}, 48'hFFFF_FFFF_FFFF);
		send_entry(32'hFFFF_FFFF);
		send_entry(32'hFFFF_FFFF);
		send_request({60'h0, MODE_THREE}, 48'h0);
		send_entry(32'h0000_0001);
		send_entry(32'h0000_0001);
		send_entry(32'h0000_0001);
		send_request({60'h1234_5678_9AB_CDEF, MODE_FOUR}, 48'hFFFF_FFFF_FFFF);
		send_entry(32'hFFFF_F001);
		send_entry(32'h1FFF_F001);
		send_entry(32'hE000_0FFF);
		send_entry(32'hFFFF_FFFF);
		// split mode with the high half selected, then the low half
		send_request({60'h0, MODE_SPLIT}, 48'h0000_8000_0000);
		send_entry(32'h1FFF_F001);
		send_entry(32'h0000_0003);
		send_request({60'hFFF_FFFF_FFFF_FFFF, MODE_SPLIT}, 48'hFFFF_7FFF_FFFF);
		send_entry(32'hFFFF_FFFE);
		// unsupported formats, then a response with no walk open
		send_request(64'h0, 48'hFFFF_FFFF_FFFF);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 48'h0);
		send_entry(32'hFFFF_FFFF);
		// new request abandons the walk in progress, leaf faults
		send_request({60'h0_0000_0ABC_D000, MODE_FOUR}, 48'h5A5A_A5A5_5A5A);
		send_entry(32'hFFFF_FFFF);
		send_request({60'h0_0000_0123_4000, MODE_TWO}, 48'hA5A5_5A5A_A5A5);
		send_entry(32'h0ABC_D001);
		send_entry(32'h0000_0000);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			case (ph)
				0: write_regs('0, '0);
				1: write_regs(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				2: write_regs(48'hFFFF_FFFF_FFFF, '0);
				3: write_regs('0, 64'hFFFF_FFFF_FFFF_FFFF);
				default: write_regs(48'({$urandom, $urandom}), {$urandom, $urandom});
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				random_walk(n);
				sent += n;
				if ($urandom_range(199) == 0)
					drain();
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
